>>> src/x25cp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25cp_pkg
// Types and constants shared by the call packet parser files.
// ----------------------------------------------------------------------------
package x25cp_pkg;

  localparam logic [7:0] ProtocolIdBytes = 8'd4;

  typedef enum logic [3:0] {
    KindCalled      = 4'd0,
    KindCalling     = 4'd1,
    KindReverse     = 4'd2,
    KindFastSelect  = 4'd3,
    KindThroughput  = 4'd4,
    KindUserGroup   = 4'd5,
    KindModAddr     = 4'd6,
    KindPacketSize  = 4'd7,
    KindWindow      = 4'd8,
    KindTransit     = 4'd9,
    KindProtocol    = 4'd10,
    KindUserData    = 4'd11,
    KindEnd         = 4'd12
  } kind_e;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrCut     = 2'd1;
  localparam logic [1:0] ErrOverrun = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [7:0]  position;
    logic [1:0]  error;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [7:0]  position;
    logic [1:0]  error;
  } result_t;

  // results of one byte, slot 0 first
  typedef struct packed {
    result_t [2:0] slot;
    logic [1:0]    count;
  } bundle_t;

endpackage

>>> src/x25cp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25cp_parse
// Packet state and byte decode; builds the result bundle of one byte.
// ----------------------------------------------------------------------------
module x25cp_parse import x25cp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_word_t word_i,
  output bundle_t  bundle_o
);

  typedef enum logic [7:0] {
    PhIdle    = 8'b0000_0001,
    PhAddrLen = 8'b0000_0010,
    PhDigits  = 8'b0000_0100,
    PhFacLen  = 8'b0000_1000,
    PhFacCode = 8'b0001_0000,
    PhFacParm = 8'b0010_0000,
    PhFacSkip = 8'b0100_0000,
    PhTail    = 8'b1000_0000
  } phase_e;

  localparam logic [1:0] ClsShort = 2'd0;
  localparam logic [1:0] ClsPair  = 2'd1;
  localparam logic [1:0] ClsTriple = 2'd2;
  localparam logic [1:0] ClsVar   = 2'd3;

  localparam logic [5:0] FcReverse    = 6'd1;
  localparam logic [5:0] FcThroughput = 6'd2;
  localparam logic [5:0] FcUserGroup  = 6'd3;
  localparam logic [5:0] FcModAddr    = 6'd8;
  localparam logic [5:0] FcPacketSize = 6'd2;
  localparam logic [5:0] FcWindow     = 6'd3;
  localparam logic [5:0] FcTransit    = 6'd9;

  phase_e     phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [3:0] called_left_q, called_left_d;
  logic [3:0] calling_left_q, calling_left_d;
  logic [7:0] fac_bytes_q, fac_bytes_d;
  logic [7:0] fac_code_q, fac_code_d;
  logic [7:0] fac_param_q, fac_param_d;
  logic [7:0] fac_first_q, fac_first_d;
  logic [7:0] field_idx_q, field_idx_d;
  logic       overrun_q, overrun_d;

  function automatic result_t mk_res(kind_e k, logic [15:0] v, logic [7:0] p,
                                     logic [1:0] e);
    result_t r;
    r.kind     = k;
    r.value    = v;
    r.position = p;
    r.error    = e;
    return r;
  endfunction

  function automatic logic fac_known(logic [7:0] c);
    logic known;
    known = 1'b0;
    case (c[7:6])
      ClsShort: known = (c[5:0] == FcReverse) || (c[5:0] == FcThroughput) ||
                        (c[5:0] == FcUserGroup) || (c[5:0] == FcModAddr);
      ClsPair:  known = (c[5:0] == FcPacketSize) || (c[5:0] == FcWindow) ||
                        (c[5:0] == FcTransit);
      ClsVar:   known = 1'b1;
      default:  known = 1'b0;
    endcase
    return known;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [3:0]  nib;
    logic [1:0]  n;
    logic [7:0]  need;
    logic [7:0]  pos;
    logic        go_done;
    logic        go_skip;
    logic [15:0] grp;
    bundle_t     bun;

    b       = word_i.data_byte;
    n       = 2'd0;
    need    = 8'd1;
    pos     = 8'd0;
    nib     = 4'd0;
    go_done = 1'b0;
    go_skip = 1'b0;
    grp     = 16'({b[7:4], 3'b000}) + 16'({b[7:4], 1'b0}) + 16'(b[3:0]);
    bun     = '0;

    phase_d        = phase_q;
    bytes_left_d   = bytes_left_q;
    called_left_d  = called_left_q;
    calling_left_d = calling_left_q;
    fac_bytes_d    = fac_bytes_q;
    fac_code_d     = fac_code_q;
    fac_param_d    = fac_param_q;
    fac_first_d    = fac_first_q;
    field_idx_d    = field_idx_q;
    overrun_d      = overrun_q;

    if (word_i.packet_start) begin
      if (phase_q != PhIdle) begin
        bun.slot[n] = mk_res(KindEnd, 16'd0, 8'd0, ErrCut);
        n = n + 2'd1;
      end
      called_left_d  = 4'd0;
      calling_left_d = 4'd0;
      fac_bytes_d    = 8'd0;
      fac_code_d     = 8'd0;
      fac_param_d    = 8'd0;
      fac_first_d    = 8'd0;
      field_idx_d    = 8'd0;
      overrun_d      = 1'b0;
      bytes_left_d   = b;
      phase_d        = PhAddrLen;
      if (b == 8'd0) begin
        bun.slot[n] = mk_res(KindEnd, 16'd0, 8'd0, ErrNone);
        n = n + 2'd1;
        phase_d = PhIdle;
      end
    end else if (phase_q != PhIdle) begin
      bytes_left_d = bytes_left_q - 8'd1;
      unique case (phase_q)
        PhAddrLen: begin
          called_left_d  = b[3:0];
          calling_left_d = b[7:4];
          field_idx_d    = 8'd0;
          phase_d        = (b != 8'd0) ? PhDigits : PhFacLen;
        end
        PhDigits: begin
          for (int k = 0; k < 2; k++) begin
            nib = (k == 0) ? b[7:4] : b[3:0];
            if (called_left_d != 4'd0) begin
              bun.slot[n] = mk_res(KindCalled, {12'h003, nib}, field_idx_d, ErrNone);
              n = n + 2'd1;
              field_idx_d   = field_idx_d + 8'd1;
              called_left_d = called_left_d - 4'd1;
              if (called_left_d == 4'd0) begin
                field_idx_d = 8'd0;
              end
            end else if (calling_left_d != 4'd0) begin
              bun.slot[n] = mk_res(KindCalling, {12'h003, nib}, field_idx_d, ErrNone);
              n = n + 2'd1;
              field_idx_d    = field_idx_d + 8'd1;
              calling_left_d = calling_left_d - 4'd1;
            end
          end
          if (called_left_d == 4'd0 && calling_left_d == 4'd0) begin
            phase_d = PhFacLen;
          end
        end
        PhFacLen: begin
          fac_bytes_d = b;
          field_idx_d = 8'd0;
          go_done     = 1'b1;
        end
        PhFacCode: begin
          case (b[7:6])
            ClsPair:   need = 8'd2;
            ClsTriple: need = 8'd3;
            default:   need = 8'd1;
          endcase
          field_idx_d = field_idx_q + 8'd1;
          fac_bytes_d = fac_bytes_q - 8'd1;
          fac_code_d  = b;
          if (need > fac_bytes_d) begin
            go_skip = 1'b1;
          end else begin
            fac_param_d = need;
            phase_d     = fac_known(b) ? PhFacParm : PhFacSkip;
          end
        end
        PhFacParm: begin
          pos         = field_idx_q;
          field_idx_d = field_idx_q + 8'd1;
          fac_bytes_d = fac_bytes_q - 8'd1;
          fac_param_d = fac_param_q - 8'd1;
          if (fac_code_q[7:6] == ClsVar) begin
            if (b > fac_bytes_d) begin
              go_skip = 1'b1;
            end else if (b == 8'd0) begin
              go_done = 1'b1;
            end else begin
              fac_param_d = b;
              phase_d     = PhFacSkip;
            end
          end else if (fac_param_d != 8'd0) begin
            fac_first_d = b;
          end else begin
            go_done = 1'b1;
            if (fac_code_q[7:6] == ClsShort) begin
              case (fac_code_q[5:0])
                FcReverse: begin
                  bun.slot[n] = mk_res(KindReverse, {15'd0, b[0]}, pos, ErrNone);
                  n = n + 2'd1;
                  bun.slot[n] = mk_res(KindFastSelect,
                                       b[7] ? {14'd0, b[7:6]} : 16'd0, pos, ErrNone);
                  n = n + 2'd1;
                end
                FcThroughput: begin
                  bun.slot[n] = mk_res(KindThroughput, {4'd0, b[7:4], 4'd0, b[3:0]},
                                       pos, ErrNone);
                  n = n + 2'd1;
                end
                FcUserGroup: begin
                  bun.slot[n] = mk_res(KindUserGroup, grp, pos, ErrNone);
                  n = n + 2'd1;
                end
                FcModAddr: begin
                  bun.slot[n] = mk_res(KindModAddr, {8'd0, b}, pos, ErrNone);
                  n = n + 2'd1;
                end
                default: ;
              endcase
            end else if (fac_code_q[7:6] == ClsPair) begin
              case (fac_code_q[5:0])
                FcPacketSize: begin
                  bun.slot[n] = mk_res(KindPacketSize, {fac_first_q, b}, pos, ErrNone);
                  n = n + 2'd1;
                end
                FcWindow: begin
                  bun.slot[n] = mk_res(KindWindow, {fac_first_q, b}, pos, ErrNone);
                  n = n + 2'd1;
                end
                FcTransit: begin
                  bun.slot[n] = mk_res(KindTransit, {fac_first_q, b}, pos, ErrNone);
                  n = n + 2'd1;
                end
                default: ;
              endcase
            end
          end
        end
        PhFacSkip: begin
          field_idx_d = field_idx_q + 8'd1;
          fac_bytes_d = fac_bytes_q - 8'd1;
          fac_param_d = fac_param_q - 8'd1;
          if (fac_param_d == 8'd0) begin
            go_done = 1'b1;
          end
        end
        PhTail: begin
          if (field_idx_q < ProtocolIdBytes) begin
            bun.slot[n] = mk_res(KindProtocol, {8'd0, b}, field_idx_q, ErrNone);
          end else begin
            bun.slot[n] = mk_res(KindUserData, {8'd0, b},
                                 field_idx_q - ProtocolIdBytes, ErrNone);
          end
          n = n + 2'd1;
          field_idx_d = field_idx_q + 8'd1;
        end
        default: ;
      endcase

      // facility overrun: drop the rest of the field
      if (go_skip) begin
        overrun_d   = 1'b1;
        fac_param_d = fac_bytes_d;
        if (fac_bytes_d != 8'd0) begin
          phase_d = PhFacSkip;
        end else begin
          go_done = 1'b1;
        end
      end
      if (go_done) begin
        if (fac_bytes_d != 8'd0) begin
          phase_d = PhFacCode;
        end else begin
          phase_d     = PhTail;
          field_idx_d = 8'd0;
        end
      end

      if (bytes_left_d == 8'd0) begin
        bun.slot[n] = mk_res(KindEnd, 16'd0, 8'd0, overrun_d ? ErrOverrun : ErrNone);
        n = n + 2'd1;
        phase_d = PhIdle;
      end
    end

    bun.count = n;
    bundle_o  = bun;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      bytes_left_q   <= 8'd0;
      called_left_q  <= 4'd0;
      calling_left_q <= 4'd0;
      fac_bytes_q    <= 8'd0;
      fac_code_q     <= 8'd0;
      fac_param_q    <= 8'd0;
      fac_first_q    <= 8'd0;
      field_idx_q    <= 8'd0;
      overrun_q      <= 1'b0;
    end else if (fire_i) begin
      phase_q        <= phase_d;
      bytes_left_q   <= bytes_left_d;
      called_left_q  <= called_left_d;
      calling_left_q <= calling_left_d;
      fac_bytes_q    <= fac_bytes_d;
      fac_code_q     <= fac_code_d;
      fac_param_q    <= fac_param_d;
      fac_first_q    <= fac_first_d;
      field_idx_q    <= field_idx_d;
      overrun_q      <= overrun_d;
    end
  end

endmodule

>>> src/x25cp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25cp_outq
// Result register: holds the bundle of one byte and hands it out word by word.
// ----------------------------------------------------------------------------
module x25cp_outq import x25cp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  bundle_t   bundle_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  result_t [2:0] slot_q;
  logic [1:0]    count_q;
  logic [1:0]    idx_q;
  logic          last;
  logic          pop;
  result_t       cur;

  assign cur         = slot_q[idx_q];
  assign last        = (idx_q == (count_q - 2'd1));
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (count_q == 2'd0) || (pop && last);

  assign out_word_o.kind        = cur.kind;
  assign out_word_o.value       = cur.value;
  assign out_word_o.position    = cur.position;
  assign out_word_o.error       = cur.error;
  assign out_word_o.last_of_run = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      count_q <= bundle_i.count;
      idx_q   <= 2'd0;
    end else if (pop) begin
      if (last) begin
        count_q <= 2'd0;
        idx_q   <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end
  end

endmodule

>>> src/x25_call_packet_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25_call_packet_parser
// Parses a length-prefixed call packet byte by byte into address digits,
// decoded facilities, protocol-id bytes, user data and an end event.
//
//   channel  direction  payload     handshake
//   in       input      in_word_t   in_valid_i / in_stall_o
//   out      output     out_word_t  out_valid_o / out_stall_i
//
// a byte is held in the input register, then is decoded in one pass
// into up to three result words held in the result register
// one byte per cycle while each byte gives at most one word and out_stall_i
// is low; a byte giving more words holds the result register until its last
// word leaves; reset returns the parser to idle, waiting for a length byte
// an output stall holds the result register, then the input register
// ----------------------------------------------------------------------------
module x25_call_packet_parser import x25cp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  in_word_t in_word_q;
  logic     in_valid_q;
  logic     free;
  logic     fire;
  logic     accept;
  bundle_t  bundle;

  assign fire       = in_valid_q && free;
  assign in_stall_o = in_valid_q && !free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept || (in_valid_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
  end

  x25cp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .word_i   (in_word_q),
    .bundle_o (bundle)
  );

  x25cp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
